// ===== design/iaht_pkg.sv =====
`default_nettype none

package iaht_pkg;

  localparam int BUCKETS = 256;
  localparam int WAYS    = 4;
  localparam int ADDR_W  = 32;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W  = $clog2(WAYS + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] STS_INSERTED = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_HIT      = 2'd2;
  localparam logic [1:0] STS_MISS     = 2'd3;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       present;
  } out_item_t;

  typedef logic [WAYS-1:0][ADDR_W-1:0] row_t;

endpackage

`default_nettype wire

// ===== design/ipv4_allowlist_hash_table.sv =====
`default_nettype none

// flow: an accepted item and its bucket row, fill count and valid bit are
// registered on entry to ST_EVAL, ahead of the read-modify-write; the result and
// its strobe are then registered from them, and the receiver cannot stall the
// result; busy is high in ST_EVAL, so no new item is taken until it is done
// reset: synchronous active-low rst_n empties every bucket at once through
// per-bucket valid bits; entry storage is not cleared and needs no sweep
module ipv4_allowlist_hash_table
  import iaht_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  row_t              ent_mem [BUCKETS];
  logic [FILL_W-1:0] fill_mem [BUCKETS];
  logic [BUCKETS-1:0] valid_r;

  row_t              row_rd_r;
  logic [FILL_W-1:0] fill_rd_r;
  logic              fill_ok_r;
  in_item_t          item_r;
  out_item_t         out_item_r, out_item_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              accept;
  logic [BKT_W-1:0]  rd_bkt;
  logic [BKT_W-1:0]  bkt;
  logic [FILL_W-1:0] fill;
  logic              full;
  logic              hit;
  logic              wr_en;

  assign accept = start && (state_r == ST_IDLE);
  assign rd_bkt = in_item.address[BKT_W-1:0];
  assign bkt    = item_r.address[BKT_W-1:0];
  assign fill   = fill_ok_r ? fill_rd_r : '0;
  assign full   = (fill >= FILL_W'(WAYS));
  assign wr_en  = (state_r == ST_EVAL) && (item_r.command == CMD_INSERT) && !full;

  iaht_match u_match (
    .row     (row_rd_r),
    .fill    (fill),
    .address (item_r.address),
    .hit     (hit)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      row_rd_r  <= ent_mem[rd_bkt];
      fill_rd_r <= fill_mem[rd_bkt];
      fill_ok_r <= valid_r[rd_bkt];
      item_r    <= in_item;
    end
    if (wr_en) begin
      ent_mem[bkt][fill[WAY_W-1:0]] <= item_r.address;
      fill_mem[bkt]                 <= fill + FILL_W'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (item_r.command == CMD_INSERT) begin
          out_item_nxt.status  = full ? STS_FULL : STS_INSERTED;
          out_item_nxt.present = 1'b0;
        end else begin
          out_item_nxt.status  = hit ? STS_HIT : STS_MISS;
          out_item_nxt.present = hit;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[bkt] <= 1'b1;
      end
    end
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r == ST_EVAL);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_strobe_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EVAL))
    else $error("result strobe without evaluation");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EVAL))
    else $error("accepted item not evaluated");

  a_present_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.present) |-> (out_item_r.status == STS_HIT))
    else $error("present without lookup hit");

  a_insert_marks_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(bkt)])
    else $error("inserted bucket not marked valid");

endmodule

`default_nettype wire

// ===== design/iaht_match.sv =====
`default_nettype none

module iaht_match
  import iaht_pkg::*;
(
  input  row_t              row,
  input  logic [FILL_W-1:0] fill,
  input  logic [ADDR_W-1:0] address,
  output logic              hit
);

  // only filled ways take part in the compare
  always_comb begin
    hit = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if ((FILL_W'(w) < fill) && (row[w] == address)) begin
        hit = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
